FILE: sv/tsh64_pkg.sv
package tsh64_pkg;

    localparam int TABLE_ROWS_DEF = 5;

    // crypt table generator: seed = (seed * GEN_MUL + GEN_INC) mod GEN_MOD
    localparam int                SEED_W    = 22;
    localparam logic [SEED_W-1:0] GEN_START = 22'h100001;
    localparam logic [SEED_W-1:0] GEN_MOD   = 22'h2AAAAB;
    localparam int                MUL_W     = 7;
    localparam logic [MUL_W-1:0]  GEN_MUL   = 7'd125;
    localparam int                BIT_W     = $clog2(MUL_W);
    localparam logic [1:0]        GEN_INC   = 2'd3;
    localparam int                HALF_W    = 16;
    localparam int                WORD_W    = 2 * HALF_W;

    localparam logic [63:0] ONE_INIT = 64'h0000_0000_7FED_7FED;
    localparam logic [63:0] TWO_INIT = 64'h0000_0000_EEEE_EEEE;

    // configuration port
    localparam int                   CFG_W         = 3;
    localparam int                   CFG_IDX_W     = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SEL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_SENS = 2'd1;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0] row_sel;
        logic       case_sens;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [7:0]        ch;
        logic              upd;
        logic              last;
    } t_work;

    typedef enum logic [1:0] {
        G_STEP,
        G_ADD3,
        G_DONE
    } t_gen_state;

endpackage

FILE: sv/tsh64_ram.sv
module tsh64_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1280,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/tsh64_gen.sv
module tsh64_gen #(
    parameter int TABLE_ROWS = tsh64_pkg::TABLE_ROWS_DEF,
    localparam int ADDR_W = $clog2(TABLE_ROWS * 256)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    output logic                        o_we,
    output logic [ADDR_W-1:0]           o_waddr,
    output logic [tsh64_pkg::WORD_W-1:0] o_wdata,
    output logic                        o_done
);

    import tsh64_pkg::*;

    localparam int ROW_W = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;

    // one modular reduction of a value known to be below 2 * GEN_MOD
    function automatic logic [SEED_W-1:0] mod_fix(input logic [SEED_W:0] v);
        logic [SEED_W:0] d;
        d = v - {1'b0, GEN_MOD};
        mod_fix = (v >= {1'b0, GEN_MOD}) ? d[SEED_W-1:0] : v[SEED_W-1:0];
    endfunction

    t_gen_state        r_state, n_state;
    logic [SEED_W-1:0] r_seed, n_seed;
    logic [SEED_W-1:0] r_acc, n_acc;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_half, n_half;
    logic [HALF_W-1:0] r_hi, n_hi;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [7:0]        r_col, n_col;

    logic [SEED_W-1:0] w_dbl;
    logic [SEED_W:0]   w_sum;
    logic [SEED_W-1:0] w_step;
    logic [SEED_W-1:0] w_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_STEP;
            r_seed  <= GEN_START;
            r_acc   <= '0;
            r_bit   <= BIT_W'(MUL_W - 1);
            r_half  <= 1'b0;
            r_hi    <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_seed  <= n_seed;
            r_acc   <= n_acc;
            r_bit   <= n_bit;
            r_half  <= n_half;
            r_hi    <= n_hi;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    // Horner step over the multiplier bits, MSB first: acc = 2*acc (+ seed)
    assign w_dbl  = mod_fix({r_acc, 1'b0});
    assign w_sum  = {1'b0, w_dbl} + (GEN_MUL[r_bit] ? {1'b0, r_seed} : '0);
    assign w_step = mod_fix(w_sum);
    assign w_inc  = mod_fix({1'b0, r_acc} + (SEED_W + 1)'(GEN_INC));

    always_comb begin
        n_state = r_state;
        n_seed  = r_seed;
        n_acc   = r_acc;
        n_bit   = r_bit;
        n_half  = r_half;
        n_hi    = r_hi;
        n_row   = r_row;
        n_col   = r_col;
        o_we    = 1'b0;
        o_waddr = (ADDR_W'(r_row) << 8) | ADDR_W'(r_col);
        o_wdata = {r_hi, w_inc[HALF_W-1:0]};
        o_done  = 1'b0;
        case (r_state)
            G_STEP: begin
                n_acc = w_step;
                if (r_bit == '0) begin
                    n_state = G_ADD3;
                end else begin
                    n_bit = r_bit - 1'b1;
                end
            end
            G_ADD3: begin
                n_seed  = w_inc;
                n_acc   = '0;
                n_bit   = BIT_W'(MUL_W - 1);
                n_state = G_STEP;
                if (!r_half) begin
                    n_hi   = w_inc[HALF_W-1:0];
                    n_half = 1'b1;
                end else begin
                    o_we   = 1'b1;
                    n_half = 1'b0;
                    // column-major fill: rows inner, columns outer
                    if (r_row == ROW_W'(TABLE_ROWS - 1)) begin
                        n_row = '0;
                        if (r_col == 8'hFF) begin
                            n_state = G_DONE;
                        end else begin
                            n_col = r_col + 1'b1;
                        end
                    end else begin
                        n_row = r_row + 1'b1;
                    end
                end
            end
            G_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                n_state = G_STEP;
            end
        endcase
    end

endmodule

FILE: sv/tsh64_front.sv
module tsh64_front #(
    parameter int TABLE_ROWS = tsh64_pkg::TABLE_ROWS_DEF,
    localparam int ADDR_W = $clog2(TABLE_ROWS * 256)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tsh64_pkg::t_cfg               i_cfg,
    input  logic                          i_tbl_done,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_byte_in,
    input  logic                          i_last,
    input  logic [tsh64_pkg::Q_CNT_W-1:0] i_q_cnt,
    output logic                          o_re,
    output logic [ADDR_W-1:0]             o_raddr,
    input  logic [tsh64_pkg::WORD_W-1:0]  i_rdata,
    output logic                          o_push,
    output tsh64_pkg::t_work              o_work
);

    import tsh64_pkg::*;

    logic       r_ended, n_ended;
    logic       r_s1_valid;
    logic [7:0] r_s1_ch;
    logic       r_s1_upd;
    logic       r_s1_last;

    logic               w_ready;
    logic               w_acc;
    logic [Q_CNT_W-1:0] w_used;
    logic [7:0]         w_ch;
    logic [3:0]         w_ht;
    logic [3:0]         w_row;
    logic               w_upd;

    // a word already in the table read counts against queue room
    assign w_used  = i_q_cnt + Q_CNT_W'(r_s1_valid);
    assign w_ready = i_tbl_done && (w_used < Q_CNT_W'(Q_DEPTH));
    assign w_acc   = i_in_valid && w_ready;

    assign o_in_stall = !w_ready;

    assign w_ch = (!i_cfg.case_sens && (i_byte_in inside {[8'h41:8'h5A]}))
                  ? i_byte_in + 8'h20 : i_byte_in;
    assign w_ht  = {1'b0, i_cfg.row_sel};
    assign w_row = (w_ht >= 4'(TABLE_ROWS)) ? 4'(TABLE_ROWS - 1) : w_ht;
    assign w_upd = !r_ended && (i_byte_in != 8'h00);

    assign o_re    = w_acc;
    assign o_raddr = (ADDR_W'(w_row) << 8) | ADDR_W'(w_ch);

    always_comb begin
        n_ended = r_ended;
        if (w_acc) begin
            n_ended = i_last ? 1'b0 : (r_ended || (i_byte_in == 8'h00));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_ended    <= n_ended;
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_ch   <= w_ch;
            r_s1_upd  <= w_upd;
            r_s1_last <= i_last;
        end
    end

    assign o_push      = r_s1_valid;
    assign o_work.word = i_rdata;
    assign o_work.ch   = r_s1_ch;
    assign o_work.upd  = r_s1_upd;
    assign o_work.last = r_s1_last;

endmodule

FILE: sv/tsh64_back.sv
module tsh64_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  tsh64_pkg::t_work              i_work,
    output logic [tsh64_pkg::Q_CNT_W-1:0] o_q_cnt,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [63:0]                   o_hash_value
);

    import tsh64_pkg::*;

    localparam logic [63:0] ACC_INC = 64'd3;

    t_work              r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic [63:0]        r_a1, n_a1;
    logic [63:0]        r_a2, n_a2;
    logic               r_out_valid, n_out_valid;
    logic [63:0]        r_hash, n_hash;

    t_work       w_head;
    logic        w_pop;
    logic [63:0] w_one;
    logic [63:0] w_two;
    logic [63:0] w_a1;
    logic [63:0] w_a2;

    assign w_head = r_q[r_rd];
    // a final word needs the result register free, or freed this cycle
    assign w_pop  = (r_cnt != '0) && (!w_head.last || !r_out_valid || !i_out_stall);

    assign w_one = {32'h0, w_head.word} ^ (r_a1 + r_a2);
    assign w_two = 64'(w_head.ch) + w_one + r_a2 + (r_a2 << 5) + ACC_INC;
    assign w_a1  = w_head.upd ? w_one : r_a1;
    assign w_a2  = w_head.upd ? w_two : r_a2;

    always_comb begin
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_cnt       = r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(w_pop);
        n_a1        = r_a1;
        n_a2        = r_a2;
        n_out_valid = r_out_valid && i_out_stall;
        n_hash      = r_hash;
        if (i_push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (w_head.last) begin
                n_out_valid = 1'b1;
                n_hash      = w_a1;
                n_a1        = ONE_INIT;
                n_a2        = TWO_INIT;
            end else begin
                n_a1 = w_a1;
                n_a2 = w_a2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd        <= '0;
            r_wr        <= '0;
            r_cnt       <= '0;
            r_a1        <= ONE_INIT;
            r_a2        <= TWO_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_rd        <= n_rd;
            r_wr        <= n_wr;
            r_cnt       <= n_cnt;
            r_a1        <= n_a1;
            r_a2        <= n_a2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
        if (i_push) begin
            r_q[r_wr] <= i_work;
        end
    end

    assign o_q_cnt      = r_cnt;
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

endmodule

FILE: sv/table_string_hash_64_unit.sv
// One byte per cycle unless stalled; o_in_stall rises in table fill or on a full queue.
// After the last byte is taken, the result goes through the table read, the queue write,
// then the accumulator step in the back end, which waits while a held result is stalled.
// Reset (i_rst_n low, synchronous) clears control state and restarts the crypt table fill:
// two generator steps per 32-bit table word over TABLE_ROWS*256 words, during which no
// byte is taken; configuration writes are taken throughout.
module table_string_hash_64_unit #(
    parameter int TABLE_ROWS = tsh64_pkg::TABLE_ROWS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [7:0]                      i_byte_in,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [63:0]                     o_hash_value,
    input  logic                            i_cfg_we,
    input  logic [tsh64_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tsh64_pkg::CFG_W-1:0]     i_cfg_data
);

    import tsh64_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_ROWS * 256);

    t_cfg r_cfg;

    logic               w_tbl_we;
    logic [ADDR_W-1:0]  w_tbl_waddr;
    logic [WORD_W-1:0]  w_tbl_wdata;
    logic               w_tbl_done;
    logic               w_tbl_re;
    logic [ADDR_W-1:0]  w_tbl_raddr;
    logic [WORD_W-1:0]  w_tbl_rdata;
    logic [Q_CNT_W-1:0] w_q_cnt;
    logic               w_push;
    t_work              w_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_sel   <= 3'd0;
            r_cfg.case_sens <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROW_SEL:   r_cfg.row_sel   <= i_cfg_data[2:0];
                CFG_CASE_SENS: r_cfg.case_sens <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tsh64_gen #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_we    (w_tbl_we),
        .o_waddr (w_tbl_waddr),
        .o_wdata (w_tbl_wdata),
        .o_done  (w_tbl_done)
    );

    tsh64_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ROWS * 256)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tbl_we),
        .i_waddr (w_tbl_waddr),
        .i_wdata (w_tbl_wdata),
        .i_re    (w_tbl_re),
        .i_raddr (w_tbl_raddr),
        .o_rdata (w_tbl_rdata)
    );

    tsh64_front #(
        .TABLE_ROWS (TABLE_ROWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_tbl_done (w_tbl_done),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_byte_in  (i_byte_in),
        .i_last     (i_last),
        .i_q_cnt    (w_q_cnt),
        .o_re       (w_tbl_re),
        .o_raddr    (w_tbl_raddr),
        .i_rdata    (w_tbl_rdata),
        .o_push     (w_push),
        .o_work     (w_work)
    );

    tsh64_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_work       (w_work),
        .o_q_cnt      (w_q_cnt),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

    a_no_byte_before_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> w_tbl_done)
        else $error("byte taken before crypt table fill finished");

    a_no_fill_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tbl_we |-> !w_tbl_done)
        else $error("crypt table written after fill finished");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_cnt <= Q_CNT_W'(Q_DEPTH))
        else $error("front/back queue overflow");

    a_push_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> $past(i_in_valid && !o_in_stall))
        else $error("queue word without a taken byte");

endmodule
